FILE: rtl/sme_pkg.sv
// Shared types and constants for the stack-machine executor.
// Opcode codes, decoded operation, queue item and status codes.
// No dependencies; compile first.
`default_nettype none

package sme_pkg;

    // Field widths of the instruction and result channels
    localparam int KIND_W    = 4;
    localparam int OPERAND_W = 32;
    localparam int NEXT_PC_W = 16;
    localparam int TOP_W     = 32;
    localparam int DEPTH_W   = 9;
    localparam int STATUS_W  = 3;

    // Defaults for the top-level parameters
    localparam int STACK_DEPTH_DEF = 256;
    localparam int PC_WIDTH_DEF    = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    // Entries in the queue between decode and execute
    localparam int QUEUE_DEPTH = 2;

    // Opcode encodings on the instruction channel
    localparam logic [KIND_W-1:0] KIND_PUSH  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_ADD   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_SUB   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_JMP   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_JZ    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_STORE = 4'd7;
    localparam logic [KIND_W-1:0] KIND_CALL  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_RET   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_HALT  = 4'd10;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_POP   = 4'd1,
        OP_ADD   = 4'd2,
        OP_SUB   = 4'd3,
        OP_JMP   = 4'd4,
        OP_JZ    = 4'd5,
        OP_LOAD  = 4'd6,
        OP_STORE = 4'd7,
        OP_CALL  = 4'd8,
        OP_RET   = 4'd9,
        OP_HALT  = 4'd10,
        OP_NOP   = 4'd11
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN     = 3'd0,
        ST_HALT    = 3'd1,
        ST_UNDER   = 3'd2,
        ST_OVER    = 3'd3,
        ST_BADADDR = 3'd4
    } status_t;

    // Decoded instruction handed from the front end to the execute unit
    typedef struct packed {
        op_t                          op;
        logic signed [OPERAND_W-1:0]  operand;
        logic                         idx_ok;   // operand is a legal stack index
        logic                         tgt_ok;   // operand is a legal program target
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/sme_if.sv
// Valid/ready channel interfaces for the stack-machine executor.
// Depends on sme_pkg for field widths.
`default_nettype none

interface sme_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic        [sme_pkg::KIND_W-1:0]     kind;
    logic signed [sme_pkg::OPERAND_W-1:0]  operand;

    modport source (output valid, output kind, output operand, input ready);
    modport sink   (input valid, input kind, input operand, output ready);
endinterface

interface sme_res_if;
    logic                                  valid;
    logic                                  ready;
    logic        [sme_pkg::NEXT_PC_W-1:0]  next_pc;
    logic signed [sme_pkg::TOP_W-1:0]      top_value;
    logic        [sme_pkg::DEPTH_W-1:0]    depth;
    logic        [sme_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output next_pc, output top_value, output depth,
                    output status, input ready);
    modport sink   (input valid, input next_pc, input top_value, input depth,
                    input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/sme_queue.sv
// Short FIFO of decoded instructions between the front end and execute unit.
// Depends on sme_pkg (item_t, QUEUE_DEPTH).
`default_nettype none

module sme_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sme_pkg::item_t  push_item,
    input  wire logic            pop,
    output sme_pkg::item_t       head,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_W = (sme_pkg::QUEUE_DEPTH > 1) ? $clog2(sme_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sme_pkg::QUEUE_DEPTH + 1);

    sme_pkg::item_t     slot_reg [sme_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(sme_pkg::QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign full  = (count_reg == CNT_W'(sme_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(sme_pkg::QUEUE_DEPTH))
        else $error("queue count beyond capacity");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/sme_front.sv
// Front end: takes instruction transfers, classifies the opcode and checks
// the operand as stack index and program target. Depends on sme_pkg, sme_if.
`default_nettype none

module sme_front #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int PC_WIDTH    = sme_pkg::PC_WIDTH_DEF
) (
    sme_cmd_if.sink          cmd,
    input  wire logic        run_ok,
    input  wire logic        q_full,
    output logic             push,
    output sme_pkg::item_t   push_item
);

    logic [sme_pkg::OPERAND_W-1:0] opu;
    sme_pkg::op_t                  op;

    assign opu = cmd.operand;

    always_comb
    begin
        unique case (cmd.kind)
            sme_pkg::KIND_PUSH:  op = sme_pkg::OP_PUSH;
            sme_pkg::KIND_POP:   op = sme_pkg::OP_POP;
            sme_pkg::KIND_ADD:   op = sme_pkg::OP_ADD;
            sme_pkg::KIND_SUB:   op = sme_pkg::OP_SUB;
            sme_pkg::KIND_JMP:   op = sme_pkg::OP_JMP;
            sme_pkg::KIND_JZ:    op = sme_pkg::OP_JZ;
            sme_pkg::KIND_LOAD:  op = sme_pkg::OP_LOAD;
            sme_pkg::KIND_STORE: op = sme_pkg::OP_STORE;
            sme_pkg::KIND_CALL:  op = sme_pkg::OP_CALL;
            sme_pkg::KIND_RET:   op = sme_pkg::OP_RET;
            sme_pkg::KIND_HALT:  op = sme_pkg::OP_HALT;
            default:             op = sme_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        push_item.op      = op;
        push_item.operand = cmd.operand;
        push_item.idx_ok  = !opu[sme_pkg::OPERAND_W-1] &&
                            (opu < sme_pkg::OPERAND_W'(STACK_DEPTH));
        // target must be non-negative and fit in the program counter
        push_item.tgt_ok  = !opu[sme_pkg::OPERAND_W-1] && ((opu >> PC_WIDTH) == '0);
    end

    // hold off while the stack is being cleared or the queue is full
    assign cmd.ready = run_ok && !q_full;
    assign push      = cmd.valid && cmd.ready;

endmodule

`default_nettype wire

FILE: rtl/sme_back.sv
// Execute unit: stack memory, cached top, depth, program counter, status,
// and the result register. Depends on sme_pkg and sme_if.
`default_nettype none

module sme_back #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int PC_WIDTH    = sme_pkg::PC_WIDTH_DEF,
    parameter int DATA_WIDTH  = sme_pkg::DATA_WIDTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sme_pkg::item_t  head,
    input  wire logic            q_empty,
    output logic                 pop,
    output logic                 run_ok,
    sme_res_if.source            res
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_READ  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;

    logic [DATA_WIDTH-1:0]  stack_mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0]  rd_data_reg;

    sme_pkg::item_t         cur_reg;
    logic [CNT_W-1:0]       depth_reg, depth_next;
    logic [PC_WIDTH-1:0]    pc_reg, pc_next;
    logic [DATA_WIDTH-1:0]  top_reg, top_next;
    sme_pkg::status_t       status_reg, status_next;

    logic                               out_valid_reg, out_valid_next;
    logic [sme_pkg::NEXT_PC_W-1:0]      out_pc_reg;
    logic [sme_pkg::TOP_W-1:0]          out_top_reg;
    logic [sme_pkg::DEPTH_W-1:0]        out_depth_reg;
    logic [sme_pkg::STATUS_W-1:0]       out_status_reg;

    logic                   mem_re, mem_we;
    logic [ADDR_W-1:0]      mem_ra, mem_wa;
    logic [DATA_WIDTH-1:0]  mem_wd;

    logic                   exec_fire;
    logic                   ex_we;
    logic [ADDR_W-1:0]      ex_wa;
    logic [DATA_WIDTH-1:0]  ex_wd;

    logic [PC_WIDTH-1:0]    pc1, pc2, target;
    logic [DATA_WIDTH-1:0]  push_data, sum, diff;
    logic [ADDR_W-1:0]      below_top, idx;
    logic                   has1, has2, full, take, ret_ok, fault;

    // ---------------------------------------------------------------
    // sequencing: clear pass, then read state / execute state per item
    // ---------------------------------------------------------------
    assign run_ok    = (state_reg != S_CLEAR);
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || res.ready);
    assign pop       = (state_reg == S_READ) && !q_empty;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(STACK_DEPTH - 1))
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (!q_empty)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_fire)
                    state_next = S_READ;
            end
            default: state_next = S_READ;
        endcase
    end

    // ---------------------------------------------------------------
    // stack memory, single port
    // ---------------------------------------------------------------
    assign below_top = ADDR_W'(depth_reg - CNT_W'(2));

    always_comb
    begin
        mem_re = pop;
        mem_ra = (head.op == sme_pkg::OP_LOAD) ? head.operand[ADDR_W-1:0] : below_top;
        mem_we = 1'b0;
        mem_wa = clr_cnt_reg;
        mem_wd = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (exec_fire && ex_we)
        begin
            mem_we = 1'b1;
            mem_wa = ex_wa;
            mem_wd = ex_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= stack_mem[mem_ra];
    end

    // ---------------------------------------------------------------
    // execute
    // ---------------------------------------------------------------
    assign pc1       = pc_reg + PC_WIDTH'(1);
    assign pc2       = pc_reg + PC_WIDTH'(2);
    assign target    = PC_WIDTH'(cur_reg.operand);
    assign push_data = DATA_WIDTH'(cur_reg.operand);
    assign sum       = rd_data_reg + top_reg;
    assign diff      = rd_data_reg - top_reg;
    assign idx       = cur_reg.operand[ADDR_W-1:0];
    assign has1      = (depth_reg != '0);
    assign has2      = (depth_reg > CNT_W'(1));
    assign full      = (depth_reg == CNT_W'(STACK_DEPTH));
    assign take      = (top_reg == '0);
    assign ret_ok    = !top_reg[DATA_WIDTH-1] && ((top_reg >> PC_WIDTH) == '0);

    always_comb
    begin
        depth_next  = depth_reg;
        pc_next     = pc_reg;
        top_next    = top_reg;
        status_next = status_reg;
        ex_we       = 1'b0;
        ex_wa       = ADDR_W'(depth_reg);
        ex_wd       = push_data;
        if (status_reg == sme_pkg::ST_RUN)
        begin
            unique case (cur_reg.op)
                sme_pkg::OP_PUSH:
                begin
                    if (full)
                        status_next = sme_pkg::ST_OVER;
                    else
                    begin
                        ex_we      = 1'b1;
                        top_next   = push_data;
                        depth_next = depth_reg + CNT_W'(1);
                        pc_next    = pc2;
                    end
                end
                sme_pkg::OP_POP:
                begin
                    if (!has1)
                        status_next = sme_pkg::ST_UNDER;
                    else
                    begin
                        top_next   = rd_data_reg;
                        depth_next = depth_reg - CNT_W'(1);
                        pc_next    = pc1;
                    end
                end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB:
                begin
                    if (!has2)
                        status_next = sme_pkg::ST_UNDER;
                    else
                    begin
                        ex_we      = 1'b1;
                        ex_wa      = below_top;
                        ex_wd      = (cur_reg.op == sme_pkg::OP_ADD) ? sum : diff;
                        top_next   = ex_wd;
                        depth_next = depth_reg - CNT_W'(1);
                        pc_next    = pc1;
                    end
                end
                sme_pkg::OP_JMP:
                begin
                    if (!cur_reg.tgt_ok)
                        status_next = sme_pkg::ST_BADADDR;
                    else
                        pc_next = target;
                end
                sme_pkg::OP_JZ:
                begin
                    if (!has1)
                        status_next = sme_pkg::ST_UNDER;
                    else if (take && !cur_reg.tgt_ok)
                        status_next = sme_pkg::ST_BADADDR;
                    else
                    begin
                        top_next   = rd_data_reg;
                        depth_next = depth_reg - CNT_W'(1);
                        pc_next    = take ? target : pc2;
                    end
                end
                sme_pkg::OP_LOAD:
                begin
                    if (!cur_reg.idx_ok)
                        status_next = sme_pkg::ST_BADADDR;
                    else if (full)
                        status_next = sme_pkg::ST_OVER;
                    else
                    begin
                        ex_we      = 1'b1;
                        ex_wd      = rd_data_reg;
                        top_next   = rd_data_reg;
                        depth_next = depth_reg + CNT_W'(1);
                        pc_next    = pc2;
                    end
                end
                sme_pkg::OP_STORE:
                begin
                    if (!has1)
                        status_next = sme_pkg::ST_UNDER;
                    else if (!cur_reg.idx_ok)
                        status_next = sme_pkg::ST_BADADDR;
                    else
                    begin
                        ex_we      = 1'b1;
                        ex_wa      = idx;
                        ex_wd      = top_reg;
                        // the new top is the stored value when it lands just below
                        top_next   = (idx == below_top) ? top_reg : rd_data_reg;
                        depth_next = depth_reg - CNT_W'(1);
                        pc_next    = pc2;
                    end
                end
                sme_pkg::OP_CALL:
                begin
                    if (!cur_reg.tgt_ok)
                        status_next = sme_pkg::ST_BADADDR;
                    else if (full)
                        status_next = sme_pkg::ST_OVER;
                    else
                    begin
                        ex_we      = 1'b1;
                        ex_wd      = DATA_WIDTH'(pc2);
                        top_next   = DATA_WIDTH'(pc2);
                        depth_next = depth_reg + CNT_W'(1);
                        pc_next    = target;
                    end
                end
                sme_pkg::OP_RET:
                begin
                    if (!has1)
                        status_next = sme_pkg::ST_UNDER;
                    else if (!ret_ok)
                        status_next = sme_pkg::ST_BADADDR;
                    else
                    begin
                        top_next   = rd_data_reg;
                        depth_next = depth_reg - CNT_W'(1);
                        pc_next    = PC_WIDTH'(top_reg);
                    end
                end
                sme_pkg::OP_HALT:
                begin
                    status_next = sme_pkg::ST_HALT;
                    pc_next     = pc1;
                end
                sme_pkg::OP_NOP:
                begin
                    pc_next = pc1;
                end
                default:
                begin
                    pc_next = pc1;
                end
            endcase
        end
    end

    assign fault = exec_fire && (status_reg == sme_pkg::ST_RUN) &&
                   (status_next != sme_pkg::ST_RUN) && (status_next != sme_pkg::ST_HALT);

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    assign res.valid     = out_valid_reg;
    assign res.next_pc   = out_pc_reg;
    assign res.top_value = out_top_reg;
    assign res.depth     = out_depth_reg;
    assign res.status    = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            depth_reg     <= '0;
            pc_reg        <= '0;
            status_reg    <= sme_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                depth_reg  <= depth_next;
                pc_reg     <= pc_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (exec_fire)
        begin
            top_reg        <= top_next;
            out_pc_reg     <= sme_pkg::NEXT_PC_W'(pc_next);
            out_top_reg    <= (depth_next != '0) ? sme_pkg::TOP_W'(top_next) : '0;
            out_depth_reg  <= sme_pkg::DEPTH_W'(depth_next);
            out_status_reg <= status_next;
        end
    end

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_re && mem_we))
        else $error("stack memory read and written in one cycle");

    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg != sme_pkg::ST_RUN) |=> (status_reg == $past(status_reg)))
        else $error("status left a halted or fault state");

    a_fault_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        fault |=> ($stable(depth_reg) && $stable(pc_reg)))
        else $error("faulting instruction changed machine state");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |-> (depth_next <= CNT_W'(STACK_DEPTH)))
        else $error("stack depth beyond capacity");

endmodule

`default_nettype wire

FILE: rtl/stack_machine_execute.sv
// Stack-machine executor, top level: front end, instruction queue, execute unit.
// Depends on sme_pkg, sme_if, sme_front, sme_queue and sme_back.
//
// Each transfer on cmd is one already-fetched instruction (opcode and operand);
// each produces exactly one transfer on res with the program counter, top of
// stack, depth and status after the step. Each instruction passes a read state,
// then an execute state, as the stack memory is single-port: the read state
// reads the entry below the cached top (or the load index), the execute state
// computes and writes back. The next instruction leaves the queue only after
// the current one has executed; the queue takes new ones meanwhile. After
// reset the stack memory is cleared one entry per cycle, all STACK_DEPTH
// entries, with cmd.ready low. Faults (underflow, overflow, bad address) and
// halt are sticky until reset; later instructions only report the state.
`default_nettype none

module stack_machine_execute #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int PC_WIDTH    = sme_pkg::PC_WIDTH_DEF,
    parameter int DATA_WIDTH  = sme_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sme_cmd_if.sink    cmd,
    sme_res_if.source  res
);

    logic            push, pop;
    logic            q_full, q_empty;
    logic            run_ok;
    sme_pkg::item_t  push_item, head;

    sme_front #(
        .STACK_DEPTH (STACK_DEPTH),
        .PC_WIDTH    (PC_WIDTH)
    ) u_front (
        .cmd       (cmd),
        .run_ok    (run_ok),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    sme_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    sme_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .PC_WIDTH    (PC_WIDTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .run_ok  (run_ok),
        .res     (res)
    );

endmodule

`default_nettype wire
